/* sv/crw_pkg.sv */
package crw_pkg;

  // Table geometry
  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);

  // Divider: one quotient bit per step
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Counter modes; mode three behaves as a 32-bit counter
  localparam logic [1:0] MODE_GAUGE = 2'd0;
  localparam logic [1:0] MODE_C64   = 2'd2;

  // Added to the difference when a 32-bit counter wraps
  localparam logic [63:0] WRAP32 = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic [9:0]  slot;
    logic [31:0] sample_time;
    logic [63:0] sample_value;
    logic [1:0]  counter_mode;
    logic [63:0] speed_limit;
  } crw_in_t;

  typedef struct packed {
    logic [9:0]  out_slot;
    logic [31:0] out_time;
    logic [63:0] delta;
    logic [63:0] rate;
    logic        emit;
  } crw_out_t;

  // One table entry
  typedef struct packed {
    logic        vld;
    logic [31:0] ts;
    logic [63:0] value;
  } crw_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } crw_state_t;

endpackage

/* sv/counter_rate_with_wrap.sv */
// Counter rate block with wrap correction.
// Input channel (in_valid / in_stall / in_data): one polled sample per
// transaction with slot, time, reading, counter mode and speed limit.
// Output channel (out_valid / out_stall / out_data): exactly one result per
// sample, in order: slot, time, wrap-corrected delta, rate and emit flag.
// cfg_we / cfg_wdata writes allow_zero_rows; write it only while idle.
// Path: a counter sample whose slot already holds a sample and whose
// elapsed time is nonzero goes from acceptance through the table read,
// the divider load, the 64-step bit-serial divider (one quotient bit a
// cycle), the divider done cycle and the result cycle. Gauge samples,
// first samples and samples with no elapsed time skip the divider and go
// from the table read straight to the result. One sample is in flight at a
// time; the next is accepted once the result has moved into the output
// register.
// Reset (rst_n, synchronous): a clearing pass walks the 1024-entry slot
// table, one entry per cycle, holding in_stall high until it is done.
// A stalled result holds in the output register; the block finishes the
// next sample and then waits until the output register frees up.
module counter_rate_with_wrap (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  crw_pkg::crw_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output crw_pkg::crw_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  crw_pkg::crw_state_t  state_r, state_nxt;
  crw_pkg::crw_in_t     item_r;
  crw_pkg::crw_entry_t  tbl_rd;
  crw_pkg::crw_entry_t  tbl_wr;
  logic                 tbl_clearing;
  logic                 azr_r;

  logic [63:0] delta_r, delta_nxt;
  logic [63:0] rate_r, rate_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic        hit_r, hit_nxt;
  logic        gauge_r, gauge_nxt;
  logic        changed_r, changed_nxt;
  logic        out_valid_r, out_valid_nxt;
  crw_pkg::crw_out_t out_data_r, out_data_nxt;

  logic        in_acc;
  logic        out_free;
  logic        in_range;
  logic        tbl_wr_en;
  logic [64:0] sub;
  logic [63:0] delta_c;
  logic [31:0] elapsed_c;
  logic        hit_c;
  logic        gauge_c;
  logic        div_start;
  logic        div_done;
  logic [63:0] div_quo;
  logic        emit_c;

  assign in_stall = (state_r != crw_pkg::ST_IDLE) || tbl_clearing;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Slot table
  crw_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (crw_pkg::SLOT_IDX_W'(in_data.slot)),
    .rd_data  (tbl_rd),
    .wr_en    (tbl_wr_en),
    .wr_addr  (crw_pkg::SLOT_IDX_W'(item_r.slot)),
    .wr_data  (tbl_wr),
    .clearing (tbl_clearing)
  );

  crw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (delta_c),
    .divisor  (elapsed_c),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Difference and elapsed time from the entry just read
  always_comb begin
    in_range  = 32'(item_r.slot) < 32'(crw_pkg::SLOT_COUNT);
    hit_c     = in_range && tbl_rd.vld;
    gauge_c   = item_r.counter_mode == crw_pkg::MODE_GAUGE;
    elapsed_c = item_r.sample_time - tbl_rd.ts;
    sub       = {1'b0, item_r.sample_value} - {1'b0, tbl_rd.value};
    if (!hit_c) begin
      delta_c = '0;
    end else if (gauge_c) begin
      delta_c = item_r.sample_value;
    end else if (sub[64] && item_r.counter_mode != crw_pkg::MODE_C64) begin
      delta_c = sub[63:0] + crw_pkg::WRAP32;
    end else begin
      delta_c = sub[63:0];
    end
    tbl_wr.vld   = 1'b1;
    tbl_wr.ts    = item_r.sample_time;
    tbl_wr.value = item_r.sample_value;
  end

  // Emission decision on the finished rate
  assign emit_c = hit_r && (elapsed_r != '0) && (rate_r <= item_r.speed_limit) &&
                  (azr_r || (!gauge_r && rate_r != '0) || (gauge_r && changed_r));

  // Sequencer: next state and outputs
  always_comb begin
    state_nxt     = state_r;
    delta_nxt     = delta_r;
    rate_nxt      = rate_r;
    elapsed_nxt   = elapsed_r;
    hit_nxt       = hit_r;
    gauge_nxt     = gauge_r;
    changed_nxt   = changed_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    tbl_wr_en     = 1'b0;
    div_start     = 1'b0;
    case (state_r)
      crw_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = crw_pkg::ST_CALC;
        end
      end
      crw_pkg::ST_CALC: begin
        delta_nxt   = delta_c;
        elapsed_nxt = elapsed_c;
        hit_nxt     = hit_c;
        gauge_nxt   = gauge_c;
        changed_nxt = item_r.sample_value != tbl_rd.value;
        tbl_wr_en   = in_range;
        if (hit_c && !gauge_c && elapsed_c != '0) begin
          div_start = 1'b1;
          state_nxt = crw_pkg::ST_DIV;
        end else begin
          rate_nxt  = (hit_c && gauge_c) ? item_r.sample_value : '0;
          state_nxt = crw_pkg::ST_DONE;
        end
      end
      crw_pkg::ST_DIV: begin
        if (div_done) begin
          rate_nxt  = div_quo;
          state_nxt = crw_pkg::ST_DONE;
        end
      end
      crw_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.out_slot = item_r.slot;
          out_data_nxt.out_time = item_r.sample_time;
          out_data_nxt.delta    = delta_r;
          out_data_nxt.rate     = rate_r;
          out_data_nxt.emit     = emit_c;
          state_nxt             = crw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = crw_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crw_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      azr_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        azr_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    delta_r    <= delta_nxt;
    rate_r     <= rate_nxt;
    elapsed_r  <= elapsed_nxt;
    hit_r      <= hit_nxt;
    gauge_r    <= gauge_nxt;
    changed_r  <= changed_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_acc_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == crw_pkg::ST_CALC)
    else $error("accepted sample did not move to table update");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == crw_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == crw_pkg::ST_DONE)
    else $error("result appeared without a finished sample");

  a_no_write_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_clearing |-> state_r == crw_pkg::ST_IDLE)
    else $error("sample in flight during table clearing");
`endif

endmodule

/* sv/crw_table.sv */
module crw_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  logic [crw_pkg::SLOT_IDX_W-1:0]  rd_addr,
  output crw_pkg::crw_entry_t             rd_data,
  input  logic                            wr_en,
  input  logic [crw_pkg::SLOT_IDX_W-1:0]  wr_addr,
  input  crw_pkg::crw_entry_t             wr_data,
  output logic                            clearing
);

  crw_pkg::crw_entry_t                mem [crw_pkg::SLOT_COUNT];
  crw_pkg::crw_entry_t                rd_data_r;
  logic                               clearing_r;
  logic [crw_pkg::SLOT_IDX_W-1:0]     clr_cnt_r;

  // Clearing sweep after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + crw_pkg::SLOT_IDX_W'(1);
      if (clr_cnt_r == crw_pkg::SLOT_IDX_W'(crw_pkg::SLOT_COUNT - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Single write port: the sweep owns it while clearing
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

/* sv/crw_div.sv */
module crw_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic                          busy_r;
  logic                          done_r;
  logic [crw_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [31:0]                   rem_r;
  logic [63:0]                   quo_r;
  logic [31:0]                   dvs_r;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // Restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[63]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + crw_pkg::DIV_CNT_W'(1);
        if (cnt_r == crw_pkg::DIV_CNT_W'(crw_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath; the quotient builds up in the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : trial[31:0];
      quo_r <= {quo_r[62:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
